// ===== hdl/nidc_pkg.sv =====
`timescale 1ns / 1ps

package nidc_pkg;

  localparam int unsigned CharW   = 16;
  localparam int unsigned PosW    = 5;
  localparam int unsigned YearW   = 14;
  localparam int unsigned FieldW  = 7;
  localparam int unsigned SumW    = 4;

  localparam logic [PosW-1:0] IdLen  = 5'd18;
  localparam logic [PosW-1:0] PosSat = 5'd19;
  localparam logic [PosW-1:0] CheckPos = 5'd17;

  localparam logic [PosW-1:0] YearFirst  = 5'd6;
  localparam logic [PosW-1:0] YearLast   = 5'd9;
  localparam logic [PosW-1:0] MonthFirst = 5'd10;
  localparam logic [PosW-1:0] MonthLast  = 5'd11;
  localparam logic [PosW-1:0] DayFirst   = 5'd12;
  localparam logic [PosW-1:0] DayLast    = 5'd13;

  localparam logic [YearW-1:0]  YearMin  = 14'd1900;
  localparam logic [YearW-1:0]  YearMax  = 14'd2100;
  localparam logic [FieldW-1:0] MonthMax = 7'd12;
  localparam logic [FieldW-1:0] DayMax   = 7'd31;

  localparam logic [CharW-1:0] ChZero   = 16'h0030;
  localparam logic [CharW-1:0] ChNine   = 16'h0039;
  localparam logic [CharW-1:0] ChUpperX = 16'h0058;
  localparam logic [CharW-1:0] ChLowerX = 16'h0078;

  typedef enum logic [1:0] {
    STATUS_VALID   = 2'd0,
    STATUS_FORMAT  = 2'd1,
    STATUS_CONTENT = 2'd2
  } status_e;

  typedef struct packed {
    logic [PosW-1:0]   position;
    logic              chars_ok;
    logic [YearW-1:0]  year_value;
    logic              year_stopped;
    logic [FieldW-1:0] month_value;
    logic              month_stopped;
    logic [FieldW-1:0] day_value;
    logic              day_stopped;
    logic [SumW-1:0]   sum_mod;
    logic [CharW-1:0]  check_char;
  } nidc_state_t;

  localparam nidc_state_t StateRst = '{
    position:      '0,
    chars_ok:      1'b1,
    year_value:    '0,
    year_stopped:  1'b0,
    month_value:   '0,
    month_stopped: 1'b0,
    day_value:     '0,
    day_stopped:   1'b0,
    sum_mod:       '0,
    check_char:    '0
  };

  function automatic logic [3:0] weight_of(input logic [PosW-1:0] pos);
    logic [3:0] w;
    case (pos)
      5'd0, 5'd10:  w = 4'd7;
      5'd1, 5'd11:  w = 4'd9;
      5'd2, 5'd12:  w = 4'd10;
      5'd3, 5'd13:  w = 4'd5;
      5'd4, 5'd14:  w = 4'd8;
      5'd5, 5'd15:  w = 4'd4;
      5'd6, 5'd16:  w = 4'd2;
      5'd7:         w = 4'd1;
      5'd8:         w = 4'd6;
      5'd9:         w = 4'd3;
      default:      w = 4'd0;
    endcase
    return w;
  endfunction

  // valid for x below 176
  function automatic logic [SumW-1:0] mod11(input logic [6:0] x);
    logic [6:0] r;
    r = x;
    if (r >= 7'd88) r = r - 7'd88;
    if (r >= 7'd44) r = r - 7'd44;
    if (r >= 7'd22) r = r - 7'd22;
    if (r >= 7'd11) r = r - 7'd11;
    return r[SumW-1:0];
  endfunction

  function automatic logic [CharW-1:0] expected_char(input logic [SumW-1:0] s);
    logic [CharW-1:0] c;
    case (s)
      4'd0:    c = 16'h0031;
      4'd1:    c = 16'h0030;
      4'd2:    c = ChUpperX;
      4'd3:    c = 16'h0039;
      4'd4:    c = 16'h0038;
      4'd5:    c = 16'h0037;
      4'd6:    c = 16'h0036;
      4'd7:    c = 16'h0035;
      4'd8:    c = 16'h0034;
      4'd9:    c = 16'h0033;
      4'd10:   c = 16'h0032;
      default: c = 16'h0031;
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/nidc_accum.sv =====
`timescale 1ns / 1ps

module nidc_accum import nidc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [CharW-1:0] char_i,
  input  logic             last_i,
  output nidc_state_t      state_d_o,
  output nidc_state_t      state_q_o
);

  nidc_state_t state_q, state_d;
  logic        is_digit, is_x;
  logic [3:0]  digit;
  logic [6:0]  sum_raw;
  logic [YearW+3:0]  year_mul;
  logic [FieldW+3:0] month_mul, day_mul;
  logic [PosW-1:0]   pos;

  assign pos      = state_q.position;
  assign is_digit = (char_i >= ChZero) && (char_i <= ChNine);
  assign is_x     = (char_i == ChUpperX) || (char_i == ChLowerX);
  assign digit    = is_digit ? char_i[3:0] : 4'd0;
  assign sum_raw  = {3'b0, state_q.sum_mod} + {3'b0, digit} * {3'b0, weight_of(pos)};
  assign year_mul  = {4'b0, state_q.year_value} * (YearW+4)'(10) + (YearW+4)'(digit);
  assign month_mul = {4'b0, state_q.month_value} * (FieldW+4)'(10) + (FieldW+4)'(digit);
  assign day_mul   = {4'b0, state_q.day_value} * (FieldW+4)'(10) + (FieldW+4)'(digit);

  always_comb begin
    state_d = state_q;
    if (!is_digit && !is_x) begin
      state_d.chars_ok = 1'b0;
    end
    if (pos < IdLen) begin
      if (pos < CheckPos) begin
        state_d.sum_mod = mod11(sum_raw);
      end else begin
        state_d.check_char = char_i;
      end
      if (pos >= YearFirst && pos <= YearLast) begin
        if (!state_q.year_stopped) begin
          if (is_digit) state_d.year_value = year_mul[YearW-1:0];
          else          state_d.year_stopped = 1'b1;
        end
      end else if (pos >= MonthFirst && pos <= MonthLast) begin
        if (!state_q.month_stopped) begin
          if (is_digit) state_d.month_value = month_mul[FieldW-1:0];
          else          state_d.month_stopped = 1'b1;
        end
      end else if (pos >= DayFirst && pos <= DayLast) begin
        if (!state_q.day_stopped) begin
          if (is_digit) state_d.day_value = day_mul[FieldW-1:0];
          else          state_d.day_stopped = 1'b1;
        end
      end
    end
    if (pos < PosSat) begin
      state_d.position = pos + 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateRst;
    end else if (step_i) begin
      state_q <= last_i ? StateRst : state_d;
    end
  end

  assign state_d_o = state_d;
  assign state_q_o = state_q;

endmodule

// ===== hdl/nidc_judge.sv =====
`timescale 1ns / 1ps

module nidc_judge import nidc_pkg::*; (
  input  nidc_state_t state_i,
  output status_e     status_o
);

  logic [CharW-1:0] expect_c;
  logic             date_ok, check_ok;

  assign expect_c = expected_char(state_i.sum_mod);
  assign date_ok  = (state_i.year_value >= YearMin) && (state_i.year_value <= YearMax)
                 && (state_i.month_value != '0) && (state_i.month_value <= MonthMax)
                 && (state_i.day_value != '0) && (state_i.day_value <= DayMax);
  assign check_ok = (state_i.check_char == expect_c)
                 || ((expect_c == ChUpperX) && (state_i.check_char == ChLowerX));

  always_comb begin
    if (!state_i.chars_ok || state_i.position != IdLen) begin
      status_o = STATUS_FORMAT;
    end else if (date_ok && check_ok) begin
      status_o = STATUS_VALID;
    end else begin
      status_o = STATUS_CONTENT;
    end
  end

endmodule

// ===== hdl/national_id_number_checker_top.sv =====
`timescale 1ns / 1ps

// checks 18-character identity numbers streamed one utf-16 code unit per request, tlast on
// the final unit; one character is taken every cycle, save a last one behind an untaken
// status; each number yields one status request via the input register, then a result
// register behind the weighted mod-11 sum and date checks; status 0 valid, 1 bad character
// or length not 18, 2 date or check character wrong; the next number may follow at once
module national_id_number_checker_top import nidc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [15:0] char_code
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o    // [1:0] status, [7:2] zero
);

  logic             in_vld_q;
  logic [CharW-1:0] in_char_q;
  logic             in_last_q;
  logic             out_vld_q;
  status_e          out_status_q;
  logic             adv;
  logic             in_take;
  nidc_state_t      state_d, state_q;
  status_e          status;

  assign adv = in_vld_q && (!in_last_q || !out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || adv;
  assign in_take = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_char_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  nidc_accum u_accum (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (adv),
    .char_i    (in_char_q),
    .last_i    (in_last_q),
    .state_d_o (state_d),
    .state_q_o (state_q)
  );

  nidc_judge u_judge (
    .state_i  (state_d),
    .status_o (status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv && in_last_q) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_last_q) begin
      out_status_q <= status;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {6'b0, out_status_q};

`ifndef SYNTHESIS
  a_pos_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.position <= PosSat)
    else $error("position past saturation");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && in_last_q |=> state_q.position == '0 && state_q.chars_ok)
    else $error("state not cleared after last character");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !m_axis_tready_i |-> !(adv && in_last_q))
    else $error("pending status overwritten");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> out_status_q == STATUS_VALID || out_status_q == STATUS_FORMAT
                  || out_status_q == STATUS_CONTENT)
    else $error("status code out of range");
`endif

endmodule

// ===== tb/nidc_status_checker.sv =====
`timescale 1ns / 1ps

module nidc_status_checker import nidc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [15:0] s_axis_tdata_i,   // [15:0] char_code
  input  logic        s_axis_tlast_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [7:0]  m_axis_tdata_i,   // [1:0] status, [7:2] zero
  output int          fail_count_o,
  output int          pending_o
);

  int          id_weight [17] = '{7, 9, 10, 5, 8, 4, 2, 1, 6, 3, 7, 9, 10, 5, 8, 4, 2};
  logic [15:0] check_table [11] = '{16'("1"), 16'("0"), 16'("X"), 16'("9"), 16'("8"),
                                    16'("7"), 16'("6"), 16'("5"), 16'("4"), 16'("3"),
                                    16'("2")};

  int unsigned pos;
  bit          chars_ok;
  int unsigned year_val;
  bit          year_done;
  int unsigned month_val;
  bit          month_done;
  int unsigned day_val;
  bit          day_done;
  int unsigned sum_mod;
  logic [15:0] check_code;

  status_e     status_q [$];
  status_e     want_status;

  task automatic clear_number();
    pos        = 0;
    chars_ok   = 1'b1;
    year_val   = 0;
    year_done  = 1'b0;
    month_val  = 0;
    month_done = 1'b0;
    day_val    = 0;
    day_done   = 1'b0;
    sum_mod    = 0;
    check_code = '0;
  endtask

  task automatic take_char(input logic [15:0] code, input logic is_last);
    bit          is_digit;
    bit          is_x;
    int unsigned dig;
    logic [15:0] want_char;
    status_e     st;
    is_digit = (code >= ChZero) && (code <= ChNine);
    is_x     = (code == ChUpperX) || (code == ChLowerX);
    dig      = is_digit ? int'(code - ChZero) : 0;
    if (!is_digit && !is_x) chars_ok = 1'b0;
    if (pos < 18) begin
      if (pos < 17) begin
        sum_mod = (sum_mod + dig * id_weight[pos]) % 11;
      end else begin
        check_code = code;
      end
      if (pos >= 6 && pos <= 9) begin
        if (!year_done) begin
          if (is_digit) year_val = (year_val * 10 + dig) & 'h3fff;
          else year_done = 1'b1;
        end
      end else if (pos >= 10 && pos <= 11) begin
        if (!month_done) begin
          if (is_digit) month_val = (month_val * 10 + dig) & 'h7f;
          else month_done = 1'b1;
        end
      end else if (pos >= 12 && pos <= 13) begin
        if (!day_done) begin
          if (is_digit) day_val = (day_val * 10 + dig) & 'h7f;
          else day_done = 1'b1;
        end
      end
    end
    if (pos < 19) pos++;
    if (is_last) begin
      if (!chars_ok || pos != 18) begin
        st = STATUS_FORMAT;
      end else begin
        want_char = check_table[sum_mod];
        if (year_val < 1900 || year_val > 2100 || month_val < 1 || month_val > 12 ||
            day_val < 1 || day_val > 31 ||
            (check_code != want_char && !(want_char == ChUpperX && check_code == ChLowerX)))
          st = STATUS_CONTENT;
        else
          st = STATUS_VALID;
      end
      status_q.push_back(st);
      clear_number();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_number();
      status_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (status_q.size() == 0) begin
          fail_count_o <= fail_count_o + 1;
          $display("%0t: status request with none expected, expected none, actual %0d",
                   $realtime, m_axis_tdata_i[1:0]);
        end else begin
          want_status = status_q.pop_front();
          if (m_axis_tdata_i[1:0] != want_status || m_axis_tdata_i[7:2] != '0) begin
            fail_count_o <= fail_count_o + 1;
            $display("%0t: status mismatch, expected %0d pad 0, actual %0d pad %0d",
                     $realtime, want_status, m_axis_tdata_i[1:0], m_axis_tdata_i[7:2]);
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) take_char(s_axis_tdata_i, s_axis_tlast_i);
      pending_o <= status_q.size();
    end
  end

endmodule

// ===== tb/national_id_number_checker_top_tb.sv =====
`timescale 1ns / 1ps

module national_id_number_checker_top_tb import nidc_pkg::*;;

  localparam int CycleLimit = 100000;
  localparam int HoldCycles = 120;

  logic        clk_i      = 1'b0;
  logic        rst_ni     = 1'b0;
  logic        s_tvalid   = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata    = '0;
  logic        s_tlast    = 1'b0;
  logic        m_tvalid;
  logic        m_tready   = 1'b0;
  logic [7:0]  m_tdata;

  int          fail_count;
  int          pending;
  int          send_idle_pct = 33;
  int          recv_idle_pct = 58;
  int          sent_items    = 0;
  int          cycle_cnt     = 0;
  logic        hold_request  = 1'b0;

  logic [15:0] id_buf [$];
  int          id_wt [17] = '{7, 9, 10, 5, 8, 4, 2, 1, 6, 3, 7, 9, 10, 5, 8, 4, 2};
  string       check_set  = "10X98765432";

  always #5 clk_i = ~clk_i;

  national_id_number_checker_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  nidc_status_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  function automatic logic [15:0] digit_char(input int v);
    return ChZero + 16'(v % 10);
  endfunction

  function automatic logic [15:0] rand_code();
    return 16'($urandom_range(65535));
  endfunction

  task automatic fix_check();
    int sum;
    sum = 0;
    for (int i = 0; i < 17; i++) begin
      if (id_buf[i] >= ChZero && id_buf[i] <= ChNine) sum += int'(id_buf[i] - ChZero) * id_wt[i];
    end
    id_buf[17] = 16'(check_set[sum % 11]);
  endtask

  task automatic build_id(input int year, input int month, input int day);
    id_buf.delete();
    repeat (6) id_buf.push_back(digit_char($urandom_range(9)));
    id_buf.push_back(digit_char(year / 1000));
    id_buf.push_back(digit_char(year / 100));
    id_buf.push_back(digit_char(year / 10));
    id_buf.push_back(digit_char(year));
    id_buf.push_back(digit_char(month / 10));
    id_buf.push_back(digit_char(month));
    id_buf.push_back(digit_char(day / 10));
    id_buf.push_back(digit_char(day));
    repeat (3) id_buf.push_back(digit_char($urandom_range(9)));
    id_buf.push_back(ChZero);
    fix_check();
  endtask

  task automatic send_char(input logic [15:0] code, input logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= code;
    s_tlast  <= is_last;
    do @(posedge clk_i); while (!s_tready);
    sent_items++;
  endtask

  task automatic send_id();
    foreach (id_buf[i]) send_char(id_buf[i], i == id_buf.size() - 1);
  endtask

  task automatic build_good_id();
    build_id($urandom_range(1900, 2100), $urandom_range(1, 12), $urandom_range(1, 31));
  endtask

  task automatic rand_id();
    int kind;
    int idx;
    kind = $urandom_range(9);
    build_good_id();
    case (kind)
      0, 1, 2: begin
        if (id_buf[17] == ChUpperX && $urandom_range(1)) id_buf[17] = ChLowerX;
      end
      3: begin
        idx = $urandom_range(1) ? $urandom_range(5) : $urandom_range(14, 16);
        id_buf[idx] = $urandom_range(1) ? ChUpperX : ChLowerX;
        fix_check();
      end
      4: begin
        idx = $urandom_range(6, 13);
        id_buf[idx] = $urandom_range(1) ? ChLowerX : ChUpperX;
        fix_check();
      end
      5: begin
        build_id($urandom_range(9999), $urandom_range(99), $urandom_range(99));
      end
      6: begin
        case ($urandom_range(2))
          0:       id_buf[17] = digit_char($urandom_range(9));
          1:       id_buf[17] = ChUpperX;
          default: id_buf[17] = ChLowerX;
        endcase
      end
      7: begin
        id_buf[$urandom_range(17)] = rand_code();
      end
      8: begin
        if ($urandom_range(1)) id_buf.delete($urandom_range(17));
        else repeat ($urandom_range(1, 6)) id_buf.push_back(digit_char($urandom_range(9)));
      end
      default: begin
        id_buf.delete();
        repeat ($urandom_range(1, 24)) begin
          id_buf.push_back($urandom_range(1) ? digit_char($urandom_range(9)) : rand_code());
        end
      end
    endcase
    send_id();
  endtask

  // receiver side: random stalls plus one long hold-off each time hold_request is raised
  initial begin
    int hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request <= 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("national_id_number_checker_top verification failed");
    $finish;
  end

  initial begin
    int target;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    build_id(1985, 6, 15);  send_id();
    build_id(1900, 1, 1);   send_id();
    build_id(2100, 12, 31); send_id();
    build_id(1899, 6, 15);  send_id();
    build_id(2101, 6, 15);  send_id();
    build_id(2000, 0, 10);  send_id();
    build_id(2000, 13, 10); send_id();
    build_id(2000, 5, 0);   send_id();
    build_id(2000, 5, 32);  send_id();

    build_id(1990, 3, 3);
    id_buf[17] = (id_buf[17] == ChZero) ? ChNine : ChZero;
    send_id();

    // expected check char X, sent upper then lower case
    build_id(1990, 5, 5);
    while (id_buf[17] != ChUpperX) build_id(1990, 5, 5);
    send_id();
    id_buf[17] = ChLowerX;
    send_id();

    // lower case x where a digit is expected
    build_id(1990, 5, 5);
    while (id_buf[17] == ChUpperX) build_id(1990, 5, 5);
    id_buf[17] = ChLowerX;
    send_id();

    // x in the body counts as zero
    build_id(1970, 7, 7);
    id_buf[0]  = ChUpperX;
    id_buf[16] = ChLowerX;
    fix_check();
    send_id();

    // x ends the year and the month field early
    build_id(1975, 4, 4);
    id_buf[8] = ChLowerX;
    fix_check();
    send_id();
    build_id(1980, 12, 20);
    id_buf[11] = ChUpperX;
    fix_check();
    send_id();

    build_id(1985, 6, 15); id_buf[3]  = 16'h0000;     send_id();
    build_id(1985, 6, 15); id_buf[17] = 16'hffff;     send_id();
    build_id(1985, 6, 15); id_buf[10] = ChZero - 1'b1; send_id();
    build_id(1985, 6, 15); id_buf[13] = ChNine + 1'b1; send_id();

    build_id(1985, 6, 15); void'(id_buf.pop_back()); send_id();
    build_id(1985, 6, 15); id_buf.push_back(ChZero); send_id();
    id_buf.delete(); id_buf.push_back(ChNine); send_id();
    build_id(1985, 6, 15);
    repeat (7) id_buf.push_back(ChNine);
    id_buf[22] = 16'h8000;
    send_id();

    // bad character wins over a bad date
    build_id(1800, 0, 0);
    id_buf[2] = 16'("A");
    send_id();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 33; recv_idle_pct = 58; end
        1: begin send_idle_pct = 58; recv_idle_pct = 33; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      hold_request <= 1'b1;
      target = sent_items + 137;
      while (sent_items < target) rand_id();
    end

    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("national_id_number_checker_top verification clean");
    end else begin
      $display("national_id_number_checker_top verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/nidc_pkg.sv
hdl/nidc_accum.sv
hdl/nidc_judge.sv
hdl/national_id_number_checker_top.sv
tb/nidc_status_checker.sv
tb/national_id_number_checker_top_tb.sv
